[src/fpa_pkg.sv]
// Package for the fixed-point ALU: operation and fault codes, widths and pipeline records.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = DATA_W + 1;            // magnitude of a signed word
    localparam int NUM_W     = MAG_W + FRAC_BITS;     // divide numerator width
    localparam int DIV_STEPS = NUM_W;                 // one quotient bit per stage
    localparam int PROD_W    = 2 * MAG_W;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_MIN  = 4'd4,
        OP_MAX  = 4'd5,
        OP_I2F  = 4'd6,
        OP_F2I  = 4'd7,
        OP_INCR = 4'd8,
        OP_DECR = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        FAULT_NONE = 2'd0,
        FAULT_OVF  = 2'd1,
        FAULT_DIV0 = 2'd2
    } t_fault;

    // Payload that travels alongside the long divide.
    typedef struct packed {
        logic [3:0]        op;
        logic              neg;       // result sign before magnitude is known
        logic [PROD_W-1:0] mag;       // magnitude for mul/add-class results
        logic [DATA_W-1:0] direct;    // finished result that needs no packing
        logic              use_dir;
        logic [1:0]        fault;
        logic              lt;
        logic              eq;
        logic              gt;
    } t_ctl;

    // Saturate a sign and magnitude into a 32-bit word.
    function automatic logic [DATA_W:0] sat_pack(input logic neg, input logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] lim;
        logic [DATA_W-1:0] w;
        logic              ovf;
        lim = '0;
        w   = '0;
        ovf = 1'b0;
        if (neg) begin
            lim[DATA_W-1] = 1'b1;
            if (m > lim) begin
                ovf = 1'b1;
                w   = {1'b1, {(DATA_W-1){1'b0}}};
            end else begin
                w = DATA_W'(-m);
            end
        end else begin
            lim[DATA_W-2:0] = '1;
            if (m > lim) begin
                ovf = 1'b1;
                w   = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                w = m[DATA_W-1:0];
            end
        end
        return {ovf, w};
    endfunction

endpackage

[src/fpa_div_stage.sv]
// One restoring-division stage: yields one quotient bit per cycle, with stall support.
module fpa_div_stage
    import fpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_num,
    input  logic [MAG_W-1:0] i_den,
    input  t_ctl             i_ctl,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_num,
    output logic [MAG_W-1:0] o_den,
    output t_ctl             o_ctl
);

    logic [NUM_W-1:0] r_rem, r_num;
    logic [MAG_W-1:0] r_den;
    t_ctl             r_ctl;
    logic             r_valid;
    logic [NUM_W:0]   w_shift;
    logic [NUM_W:0]   w_diff;
    logic [NUM_W-1:0] n_rem, n_num;

    // Shift in the next numerator bit, try to subtract the divisor.
    always_comb begin
        w_shift = {i_rem, i_num[NUM_W-1]};
        w_diff  = w_shift - (NUM_W+1)'(i_den);
        if (!w_diff[NUM_W]) begin
            n_rem = w_diff[NUM_W-1:0];
            n_num = {i_num[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[NUM_W-1:0];
            n_num = {i_num[NUM_W-2:0], 1'b0};
        end
    end

    // Advance only when the downstream side moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_den <= i_den;
            r_ctl <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_ctl   = r_ctl;

endmodule

[src/fixed_point_alu.sv]
// Fixed-point ALU top level: decode, multiply, pipelined long divide and saturating pack.
// Usage of the signed Q-format ALU (raw 32-bit words, FRAC_BITS fraction bits).
// Input channel: i_valid/o_ready with i_operation, i_operand_a, i_operand_b.
// Output channel: o_valid/i_ready with o_result_raw, compare flags and o_fault.
// Every operation, short or long, runs down one pipeline so results leave in order.
// Pipeline: one decode stage, one product stage, one quotient bit per stage
// over the 41-bit numerator (FRAC_BITS = 8), one rounding stage and the output register.
// Throughput: one item per cycle; a new item is taken every cycle the pipe moves.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls, every stage holds and o_ready
// falls, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are left as they are.
// Multiply and divide round half away from zero; overflow saturates with
// fault 1, divide by zero gives 0 with fault 2, unused codes give 0.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [3:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_result_raw,
    output logic                     o_a_less,
    output logic                     o_a_equal,
    output logic                     o_a_greater,
    output logic [1:0]               o_fault
);

    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // ---------------- stage 1: decode, magnitudes, add-class results
    logic             r1_valid;
    t_ctl             r1_ctl;
    logic [MAG_W-1:0] r1_ma, r1_mb;
    logic [NUM_W-1:0] r1_num;

    logic [MAG_W-1:0] w_ma, w_mb;
    logic signed [DATA_W+1:0] w_sum;
    t_ctl             w_c1;
    logic             w_a_neg, w_b_neg;

    always_comb begin
        w_a_neg = i_operand_a[DATA_W-1];
        w_b_neg = i_operand_b[DATA_W-1];
        w_ma = w_a_neg ? MAG_W'(-{i_operand_a[DATA_W-1], i_operand_a})
                       : MAG_W'({1'b0, i_operand_a});
        w_mb = w_b_neg ? MAG_W'(-{i_operand_b[DATA_W-1], i_operand_b})
                       : MAG_W'({1'b0, i_operand_b});
        w_sum = '0;
        w_c1  = '0;
        w_c1.op  = i_operation;
        w_c1.lt  = i_operand_a < i_operand_b;
        w_c1.eq  = i_operand_a == i_operand_b;
        w_c1.gt  = i_operand_a > i_operand_b;
        w_c1.neg = w_a_neg ^ w_b_neg;
        unique case (i_operation)
            OP_ADD:  w_sum = (DATA_W+2)'(i_operand_a) + (DATA_W+2)'(i_operand_b);
            OP_SUB:  w_sum = (DATA_W+2)'(i_operand_a) - (DATA_W+2)'(i_operand_b);
            OP_INCR: w_sum = (DATA_W+2)'(i_operand_a) + (DATA_W+2)'(1);
            OP_DECR: w_sum = (DATA_W+2)'(i_operand_a) - (DATA_W+2)'(1);
            default: w_sum = '0;
        endcase
        unique case (i_operation) inside
            OP_ADD, OP_SUB, OP_INCR, OP_DECR: begin
                w_c1.neg = w_sum[DATA_W+1];
                w_c1.mag = w_sum[DATA_W+1] ? PROD_W'(-w_sum) : PROD_W'(w_sum);
            end
            OP_I2F: begin
                w_c1.neg = w_a_neg;
                w_c1.mag = PROD_W'(w_ma) << FRAC_BITS;
            end
            OP_MIN: begin
                w_c1.use_dir = 1'b1;
                w_c1.direct  = (i_operand_a <= i_operand_b) ? i_operand_a : i_operand_b;
            end
            OP_MAX: begin
                w_c1.use_dir = 1'b1;
                w_c1.direct  = (i_operand_a >= i_operand_b) ? i_operand_a : i_operand_b;
            end
            OP_F2I: begin
                w_c1.use_dir = 1'b1;
                w_c1.direct  = i_operand_a >>> FRAC_BITS;
            end
            OP_MUL, OP_DIV: begin
                w_c1.use_dir = 1'b0;
            end
            default: begin
                w_c1.use_dir = 1'b1;
                w_c1.direct  = '0;
            end
        endcase
        if (i_operation == OP_DIV && i_operand_b == '0) begin
            w_c1.use_dir = 1'b1;
            w_c1.direct  = '0;
            w_c1.fault   = FAULT_DIV0;
        end
    end

    // Hold the decoded item while the output side stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ctl <= w_c1;
            r1_ma  <= w_ma;
            r1_mb  <= w_mb;
            r1_num <= NUM_W'(w_ma) << FRAC_BITS;
        end
    end

    // ---------------- stage 2: magnitude product
    logic             r2_valid;
    t_ctl             r2_ctl, w_c2;
    logic [NUM_W-1:0] r2_num;
    logic [MAG_W-1:0] r2_den;
    logic [PROD_W-1:0] w_prod;

    always_comb begin
        w_prod = PROD_W'(r1_ma) * PROD_W'(r1_mb);
        w_c2   = r1_ctl;
        if (r1_ctl.op == OP_MUL) begin
            w_c2.mag = w_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ctl <= w_c2;
            r2_num <= r1_num;
            r2_den <= r1_mb;
        end
    end

    // ---------------- divide chain: one quotient bit per stage
    logic             d_valid [DIV_STEPS+1];
    logic [NUM_W-1:0] d_rem   [DIV_STEPS+1];
    logic [NUM_W-1:0] d_num   [DIV_STEPS+1];
    logic [MAG_W-1:0] d_den   [DIV_STEPS+1];
    t_ctl             d_ctl   [DIV_STEPS+1];

    assign d_valid[0] = r2_valid;
    assign d_rem[0]   = '0;
    assign d_num[0]   = r2_num;
    assign d_den[0]   = r2_den;
    assign d_ctl[0]   = r2_ctl;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (d_valid[g]),
            .i_rem   (d_rem[g]),
            .i_num   (d_num[g]),
            .i_den   (d_den[g]),
            .i_ctl   (d_ctl[g]),
            .o_valid (d_valid[g+1]),
            .o_rem   (d_rem[g+1]),
            .o_num   (d_num[g+1]),
            .o_den   (d_den[g+1]),
            .o_ctl   (d_ctl[g+1])
        );
    end

    // ---------------- rounding stage
    logic              r3_valid;
    t_ctl              r3_ctl;
    logic [PROD_W-1:0] r3_mag;
    logic              r3_neg;
    logic [PROD_W-1:0] w_rmag;
    logic [NUM_W:0]    w_twice;
    t_ctl              w_cf;

    always_comb begin
        w_cf    = d_ctl[DIV_STEPS];
        w_twice = {d_rem[DIV_STEPS], 1'b0};
        if (w_cf.op == OP_MUL) begin
            if (FRAC_BITS == 0) begin
                w_rmag = w_cf.mag;
            end else begin
                w_rmag = (w_cf.mag + (PROD_W'(1) << FRAC_BITS >> 1)) >> FRAC_BITS;
            end
        end else if (w_cf.op == OP_DIV) begin
            // Round up when remainder is at least half the divisor.
            w_rmag = PROD_W'(d_num[DIV_STEPS])
                   + PROD_W'(w_twice >= (NUM_W+1)'(d_den[DIV_STEPS]));
        end else begin
            w_rmag = w_cf.mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= d_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ctl <= w_cf;
            r3_mag <= w_rmag;
            r3_neg <= w_cf.neg && (w_rmag != '0);
        end
    end

    // ---------------- pack and output register
    logic [DATA_W:0] w_pk;
    logic [DATA_W-1:0] n_res;
    logic [1:0]        n_fault;

    always_comb begin
        w_pk = sat_pack(r3_neg, r3_mag);
        if (r3_ctl.use_dir) begin
            n_res   = r3_ctl.direct;
            n_fault = r3_ctl.fault;
        end else begin
            n_res   = w_pk[DATA_W-1:0];
            n_fault = w_pk[DATA_W] ? FAULT_OVF : FAULT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_result_raw <= n_res;
            o_fault      <= n_fault;
            o_a_less     <= r3_ctl.lt;
            o_a_equal    <= r3_ctl.eq;
            o_a_greater  <= r3_ctl.gt;
        end
    end

endmodule

[src/fpa_checker.sv]
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker
    import fpa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_ready,
    input logic              o_ready,
    input logic              o_valid,
    input logic              o_a_less,
    input logic              o_a_equal,
    input logic              o_a_greater,
    input logic [1:0]        o_fault,
    input logic [DATA_W-1:0] o_result_raw
);

    // Exactly one compare flag per result.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
        else $error("compare flags not one-hot");

    // Fault code 3 never appears.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fault == FAULT_NONE || o_fault == FAULT_OVF || o_fault == FAULT_DIV0))
        else $error("bad fault code");

    // Divide by zero always yields zero.
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault == FAULT_DIV0) |-> (o_result_raw == '0))
        else $error("divide by zero result not zero");

    // Stalled output holds its result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_raw)))
        else $error("stalled result changed");

    // Input side stalls exactly when output stalls.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output stall");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

[sim/tb_fixed_point_alu.sv]
// Testbench for the fixed-point ALU: directed table and random items against a predictor.
module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 500;

    typedef struct packed {
        logic [31:0] res;
        logic        lt;
        logic        eq;
        logic        gt;
        logic [1:0]  fault;
    } t_alu_out;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          typed;   // expected result typed in below
        t_alu_out    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [3:0]  i_operation;
    logic signed [31:0] i_operand_a;
    logic signed [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic signed [31:0] o_result_raw;
    logic        o_a_less;
    logic        o_a_equal;
    logic        o_a_greater;
    logic [1:0]  o_fault;

    t_alu_out pending_results[$];
    int       errors;
    int       cycles;

    fixed_point_alu dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a sign and magnitude into 32 bits
    function automatic logic [31:0] saturate(input bit neg, input logic [79:0] m,
                                             inout logic [1:0] f);
        if (neg) begin
            if (m > 80'h8000_0000) begin
                f = FAULT_OVF;
                return 32'h8000_0000;
            end
            return 32'(-m);
        end
        if (m > 80'h7FFF_FFFF) begin
            f = FAULT_OVF;
            return 32'h7FFF_FFFF;
        end
        return m[31:0];
    endfunction

    function automatic logic [31:0] saturate_s(input logic signed [63:0] x,
                                               inout logic [1:0] f);
        logic [63:0] m;
        m = x < 0 ? -x : x;
        return saturate(x < 0, {16'd0, m}, f);
    endfunction

    // Work out the result of one ALU operation
    function automatic t_alu_out alu_predict(input logic [3:0] op,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        t_alu_out o;
        logic [79:0] ma, mb, m, num, q, r;
        logic [1:0]  f;
        f  = FAULT_NONE;
        ma = a < 0 ? 80'(-64'(a)) : 80'(a);
        mb = b < 0 ? 80'(-64'(b)) : 80'(b);
        o.res = '0;
        case (op)
            OP_ADD:  o.res = saturate_s(64'(a) + 64'(b), f);
            OP_SUB:  o.res = saturate_s(64'(a) - 64'(b), f);
            OP_MUL: begin
                m = (ma * mb + ((80'd1 << FRAC_BITS) >> 1)) >> FRAC_BITS;
                o.res = saturate((a < 0) != (b < 0) && m != 0, m, f);
            end
            OP_DIV: begin
                if (b == 0) begin
                    f = FAULT_DIV0;
                end else begin
                    num = ma << FRAC_BITS;
                    q = num / mb;
                    r = num % mb;
                    if (r >= mb - r) q++;
                    o.res = saturate((a < 0) != (b < 0) && q != 0, q, f);
                end
            end
            OP_MIN:  o.res = a <= b ? a : b;
            OP_MAX:  o.res = a >= b ? a : b;
            OP_I2F:  o.res = saturate(a < 0, ma << FRAC_BITS, f);
            OP_F2I:  o.res = a >>> FRAC_BITS;
            OP_INCR: o.res = saturate_s(64'(a) + 1, f);
            OP_DECR: o.res = saturate_s(64'(a) - 1, f);
            default: o.res = '0;
        endcase
        o.lt = a < b;
        o.eq = a == b;
        o.gt = a > b;
        o.fault = f;
        return o;
    endfunction

    function automatic int random_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 2047)) - 1024);
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // Present one item and hold it until transferred; the caller drops valid
    task automatic send_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(alu_predict(op, a, b));
        @(negedge i_clk);
    endtask

    // Cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_alu_out got, exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_result_raw, o_a_less, o_a_equal, o_a_greater, o_fault};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.res !== exp_r.res)
                    $display("%0t: result expected %h got %h", $time, exp_r.res, got.res);
                if ({got.lt, got.eq, got.gt} !== {exp_r.lt, exp_r.eq, exp_r.gt})
                    $display("%0t: flags lt/eq/gt expected %b got %b", $time,
                             {exp_r.lt, exp_r.eq, exp_r.gt}, {got.lt, got.eq, got.gt});
                if (got.fault !== exp_r.fault)
                    $display("%0t: fault expected %0d got %0d", $time, exp_r.fault, got.fault);
                if (got !== exp_r) errors++;
            end
        end
    end

    // Receiver stalls at random, with a quiet stretch of none
    initial begin
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cycles > 2000 && cycles < 3000) i_ready <= 1'b1;
            else i_ready <= (random_gap() == 0);
        end
    end

    // Stimulus
    initial begin
        t_row rows[$];
        t_row rw;
        int   gap;
        errors = 0; cycles = 0;
        i_valid = 1'b0; i_operation = '0; i_operand_a = '0; i_operand_b = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows: extremes and error codes typed in
        rows.push_back('{OP_ADD, 32'h7FFF_FFFF, 32'h1, 1, '{32'h7FFF_FFFF, 0, 0, 1, FAULT_OVF}});
        rows.push_back('{OP_SUB, 32'h8000_0000, 32'h1, 1, '{32'h8000_0000, 1, 0, 0, FAULT_OVF}});
        rows.push_back('{OP_DIV, 32'h100, 32'h0, 1, '{32'h0, 0, 0, 1, FAULT_DIV0}});
        rows.push_back('{OP_DIV, 32'h0, 32'h0, 1, '{32'h0, 0, 1, 0, FAULT_DIV0}});
        rows.push_back('{OP_INCR, 32'h7FFF_FFFF, 32'h0, 1, '{32'h7FFF_FFFF, 0, 0, 1, FAULT_OVF}});
        rows.push_back('{OP_DECR, 32'h8000_0000, 32'h0, 1, '{32'h8000_0000, 1, 0, 0, FAULT_OVF}});
        rows.push_back('{4'd10, 32'h5, 32'h5, 1, '{32'h0, 0, 1, 0, FAULT_NONE}});
        rows.push_back('{4'd15, 32'hFFFF_FFFF, 32'h0, 1, '{32'h0, 1, 0, 0, FAULT_NONE}});
        rows.push_back('{OP_F2I, 32'hFFFF_FF80, 32'h0, 1, '{32'hFFFF_FFFF, 1, 0, 0, FAULT_NONE}});
        rows.push_back('{OP_I2F, 32'h0080_0000, 32'h0, 1, '{32'h7FFF_FFFF, 0, 0, 1, FAULT_OVF}});
        rows.push_back('{OP_I2F, 32'hFF80_0000, 32'h0, 1, '{32'h8000_0000, 1, 0, 0, FAULT_NONE}});
        // Rows left to the predictor: rounding and sign corners
        rows.push_back('{OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0});
        rows.push_back('{OP_MUL, 32'h180, 32'hFFFF_FF80, 0, '0});
        rows.push_back('{OP_MUL, 32'h1, 32'h80, 0, '0});
        rows.push_back('{OP_MUL, 32'hFFFF_FFFF, 32'h7F, 0, '0});
        rows.push_back('{OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0});
        rows.push_back('{OP_DIV, 32'h100, 32'h600, 0, '0});
        rows.push_back('{OP_DIV, 32'hFFFF_FF00, 32'h200, 0, '0});
        rows.push_back('{OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 0, '0});
        rows.push_back('{OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0});
        rows.push_back('{OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0});
        rows.push_back('{OP_ADD, 32'hFFFF_FFFF, 32'h1, 0, '0});
        rows.push_back('{OP_F2I, 32'h7FFF_FFFF, 32'h0, 0, '0});
        rows.push_back('{OP_SUB, 32'h0, 32'h8000_0000, 0, '0});

        foreach (rows[i]) begin
            rw = rows[i];
            if (rw.typed && alu_predict(rw.op, rw.a, rw.b) !== rw.want) begin
                $display("%0t: table row %0d expected %h predicted %h", $time, i, rw.want,
                         alu_predict(rw.op, rw.a, rw.b));
                errors++;
            end
            send_item(rw.op, rw.a, rw.b);
        end

        // Hold off until the pipe has drained
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge i_clk);

        // Random items, mostly valid codes and some unused ones
        for (int n = 0; n < N_RANDOM; n++) begin
            gap = (cycles > 2000 && cycles < 3000) ? 0 : random_gap();
            if (gap > 0) i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            send_item($urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9)),
                      random_operand(), random_operand());
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
        end

        // Drain and let the pipeline settle
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DIV_STEPS + 10) @(posedge i_clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/fpa_pkg.sv
src/fpa_div_stage.sv
src/fixed_point_alu.sv
src/fpa_checker.sv
sim/tb_fixed_point_alu.sv
